FILE: src/wls_pkg.sv
`timescale 1ns / 1ps
// Package for the windowed least-squares slope block: field widths, accumulator
// sizes, register indexes, status codes, controller states and command types.
// It depends on nothing; every other file of the block imports it.
package wls_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int WIN_W           = 12;
   localparam int RES_W           = 16;
   localparam int CSR_W           = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int SLOPE_W         = 48;
   localparam int STATUS_W        = 2;
   localparam int MAX_SAMPLES_DEF = 4096;

   localparam logic [WIN_W-1:0] WIN_START_RST = 12'd0;
   localparam logic [WIN_W-1:0] WIN_END_RST   = 12'd4095;
   localparam logic [RES_W-1:0] RES_RST       = 16'd960;

   localparam int CNT_W  = 13;
   localparam int SX_W   = 24;
   localparam int SY_W   = 28;
   localparam int SXY_W  = 40;
   localparam int SXX_W  = 36;
   localparam int XY_W   = WIN_W + 1 + SAMPLE_W;
   localparam int XX_W   = 2 * WIN_W;

   localparam int ACC_W     = 66;
   localparam int MPL_W     = 24;
   localparam int DEN_W     = 48;
   localparam int MAG_W     = 53;
   localparam int D_W       = 64;
   localparam int SAT_SH    = 23;
   localparam int FRAC_BITS = 24;
   localparam int QF_W      = SAT_SH + FRAC_BITS;
   localparam int MUL_STEPS = MPL_W;
   localparam int DIV_STEPS = QF_W;
   localparam int STEP_W    = 6;

   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_START = 2'd0,
      CSR_WINDOW_END   = 2'd1,
      CSR_RANGE_RES    = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_FEW   = 2'd1,
      STS_SHORT = 2'd2
   } fit_status_type;

   typedef enum logic [2:0] {
      MS_N_SXX,
      MS_SX_SX,
      MS_N_SXY,
      MS_SX_SY,
      MS_DEN_RES
   } mul_sel_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_FIT,
      OUT_FEW,
      OUT_SHORT
   } out_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_RUN,
      ST_MUL_NEXT,
      ST_DIV_RUN,
      ST_FINISH
   } wls_state_type;

   typedef struct packed {
      logic        accept;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        den_save;
      logic        num_save;
      logic        div_load;
      logic        div_step;
      out_sel_type out_sel;
   } wls_cmd_type;

   typedef struct packed {
      logic fit_trig;
      logic trace_short;
      logic fit_few;
      logic den_bad;
   } wls_stat_type;

endpackage

FILE: src/wls_req_if.sv
`timescale 1ns / 1ps
// Request channel of the slope block: valid, ready, one sample and its end-of-trace mark.
// Depends on wls_pkg for the field widths.
interface wls_req_if import wls_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

FILE: src/wls_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the slope block: valid, ready, the fitted slope and its status.
// Depends on wls_pkg for the field widths.
interface wls_rsp_if import wls_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SLOPE_W-1:0] slope;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output slope, output status, input ready);
   modport sink (input valid, input slope, input status, output ready);
endinterface

FILE: src/wls_datapath.sv
`timescale 1ns / 1ps
// Datapath of the slope block: configuration registers, trace sums, the shift-add
// multiplier, the restoring divider and the result registers. Depends on wls_pkg.
module wls_datapath import wls_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_data,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   input  wls_cmd_type                cmd,
   output wls_stat_type               st,
   output logic signed [SLOPE_W-1:0]  rsp_slope,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

   logic [WIN_W-1:0] win_start_ff;
   logic [WIN_W-1:0] win_end_ff;
   logic [RES_W-1:0] res_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             fit_done_ff, fit_done_in;
   logic             stale_ff, stale_in;

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SX_W-1:0]         sx_ff, sx_in;
   logic signed [SY_W-1:0]  sy_ff, sy_in;
   logic signed [SXY_W-1:0] sxy_ff, sxy_in;
   logic [SXX_W-1:0]        sxx_ff, sxx_in;

   logic [CMP_W-1:0]       idx_ext, start_ext, end_ext;
   logic [WIN_W-1:0]       x_val;
   logic signed [XY_W-1:0] xy_prod;
   logic [XX_W-1:0]        xx_prod;
   logic                   in_win, at_end, trace_clear;

   logic signed [ACC_W-1:0] acc_ff, mcand_ff;
   logic [MPL_W-1:0]        mplier_ff;
   logic signed [ACC_W-1:0] mcand_sel, acc_abs;
   logic [MPL_W-1:0]        mplier_sel;
   logic                    acc_keep;

   logic [DEN_W-1:0] den_ff;
   logic [MAG_W-1:0] mag_ff;
   logic             neg_ff;
   logic [D_W-1:0]   d_ff, rem_ff, mag_hi;
   logic [QF_W-1:0]  low_ff, q_ff;
   logic             sat_ff;
   logic [D_W:0]     trial, trial_sub;
   logic             trial_ge;

   logic signed [SLOPE_W-1:0] slope_ff, fit_slope;
   fit_status_type            status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WIN_START_RST;
         win_end_ff   <= WIN_END_RST;
         res_ff       <= RES_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_START: win_start_ff <= csr_data[WIN_W-1:0];
            CSR_WINDOW_END:   win_end_ff   <= csr_data[WIN_W-1:0];
            CSR_RANGE_RES:    res_ff       <= csr_data[RES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      idx_ext     = CMP_W'(idx_ff);
      start_ext   = CMP_W'(win_start_ff);
      end_ext     = CMP_W'(win_end_ff);
      in_win      = !fit_done_ff && (idx_ext >= start_ext) && (idx_ext <= end_ext);
      at_end      = !fit_done_ff && (idx_ext == end_ext);
      x_val       = idx_ext[WIN_W-1:0];
      xy_prod     = $signed({1'b0, x_val}) * req_sample;
      xx_prod     = x_val * x_val;
      trace_clear = req_last || (idx_ff == IDX_LAST);

      cnt_in = (stale_ff ? '0 : cnt_ff) + CNT_W'(in_win);
      sx_in  = (stale_ff ? '0 : sx_ff) + (in_win ? SX_W'(x_val) : '0);
      sy_in  = (stale_ff ? '0 : sy_ff) + (in_win ? SY_W'(req_sample) : '0);
      sxy_in = (stale_ff ? '0 : sxy_ff) + (in_win ? SXY_W'(xy_prod) : '0);
      sxx_in = (stale_ff ? '0 : sxx_ff) + (in_win ? SXX_W'(xx_prod) : '0);

      idx_in      = trace_clear ? '0 : idx_ff + IDX_W'(1);
      fit_done_in = trace_clear ? 1'b0 : (fit_done_ff || at_end);
      stale_in    = trace_clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         fit_done_ff <= 1'b0;
         stale_ff    <= 1'b1;
      end else if (cmd.accept) begin
         idx_ff      <= idx_in;
         fit_done_ff <= fit_done_in;
         stale_ff    <= stale_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cnt_ff <= cnt_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sxy_ff <= sxy_in;
         sxx_ff <= sxx_in;
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MS_N_SXX: begin
            mcand_sel  = ACC_W'(sxx_ff);
            mplier_sel = MPL_W'(cnt_ff);
            acc_keep   = 1'b0;
         end
         MS_SX_SX: begin
            mcand_sel  = ACC_W'(0) - ACC_W'(sx_ff);
            mplier_sel = MPL_W'(sx_ff);
            acc_keep   = 1'b1;
         end
         MS_N_SXY: begin
            mcand_sel  = ACC_W'(sxy_ff);
            mplier_sel = MPL_W'(cnt_ff);
            acc_keep   = 1'b0;
         end
         MS_SX_SY: begin
            mcand_sel  = ACC_W'(0) - ACC_W'(sy_ff);
            mplier_sel = MPL_W'(sx_ff);
            acc_keep   = 1'b1;
         end
         MS_DEN_RES: begin
            mcand_sel  = ACC_W'(den_ff);
            mplier_sel = MPL_W'(res_ff);
            acc_keep   = 1'b0;
         end
         default: begin
            mcand_sel  = '0;
            mplier_sel = '0;
            acc_keep   = 1'b0;
         end
      endcase
      acc_abs = acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;
      mag_hi  = D_W'(mag_ff[MAG_W-1:SAT_SH]);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mcand_ff  <= mcand_sel;
         mplier_ff <= mplier_sel;
         if (!acc_keep) begin
            acc_ff <= '0;
         end
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
      if (cmd.den_save) begin
         den_ff <= acc_ff[DEN_W-1:0];
      end
      if (cmd.num_save) begin
         neg_ff <= acc_ff[ACC_W-1];
         mag_ff <= acc_abs[MAG_W-1:0];
      end
   end

   always_comb begin
      trial     = {rem_ff, low_ff[QF_W-1]};
      trial_sub = trial - {1'b0, d_ff};
      trial_ge  = trial >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         d_ff   <= acc_ff[D_W-1:0];
         sat_ff <= mag_hi >= acc_ff[D_W-1:0];
         rem_ff <= mag_hi;
         low_ff <= {mag_ff[SAT_SH-1:0], {FRAC_BITS{1'b0}}};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
         low_ff <= low_ff << 1;
         q_ff   <= {q_ff[QF_W-2:0], trial_ge};
      end
   end

   always_comb begin
      if (sat_ff) begin
         fit_slope = neg_ff ? SLOPE_MIN : SLOPE_MAX;
      end else if (neg_ff) begin
         fit_slope = SLOPE_W'(0) - SLOPE_W'(q_ff);
      end else begin
         fit_slope = SLOPE_W'(q_ff);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.out_sel)
         OUT_FIT: begin
            slope_ff  <= fit_slope;
            status_ff <= STS_OK;
         end
         OUT_FEW: begin
            slope_ff  <= '0;
            status_ff <= STS_FEW;
         end
         OUT_SHORT: begin
            slope_ff  <= '0;
            status_ff <= STS_SHORT;
         end
         default: begin
         end
      endcase
   end

   assign st.fit_trig    = at_end;
   assign st.trace_short = req_last && !at_end && !fit_done_ff;
   assign st.fit_few     = (cnt_ff < CNT_W'(2)) || (res_ff == '0);
   assign st.den_bad     = acc_ff[ACC_W-1] || (acc_ff == '0);

   assign rsp_slope  = slope_ff;
   assign rsp_status = status_ff;

endmodule

FILE: src/wls_controller.sv
`timescale 1ns / 1ps
// Controller of the slope block: the handshakes and the sequence of multiply and
// divide steps that solve the fit. Depends on wls_pkg for its state and command types.
module wls_controller import wls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  wls_stat_type st,
   output wls_cmd_type  cmd
);

   wls_state_type     state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   mul_sel_type       sel_ff, sel_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = cmd.mul_load ? cmd.mul_sel : sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && st.fit_trig) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in   = '0;
            state_in = st.fit_few ? ST_IDLE : ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL_NEXT;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_MUL_NEXT: begin
            case (sel_ff)
               MS_N_SXX:   state_in = ST_MUL_RUN;
               MS_SX_SX:   state_in = st.den_bad ? ST_IDLE : ST_MUL_RUN;
               MS_N_SXY:   state_in = ST_MUL_RUN;
               MS_SX_SY:   state_in = ST_MUL_RUN;
               MS_DEN_RES: state_in = ST_DIV_RUN;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_DIV_RUN: begin
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mul_sel = MS_N_SXX;
      cmd.out_sel = OUT_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && !st.fit_trig && st.trace_short) begin
               cmd.out_sel = OUT_SHORT;
            end
         end
         ST_CHECK: begin
            if (st.fit_few) begin
               cmd.out_sel = OUT_FEW;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = MS_N_SXX;
            end
         end
         ST_MUL_RUN: cmd.mul_step = 1'b1;
         ST_MUL_NEXT: begin
            case (sel_ff)
               MS_N_SXX: begin
                  cmd.mul_load = 1'b1;
                  cmd.mul_sel  = MS_SX_SX;
               end
               MS_SX_SX: begin
                  if (st.den_bad) begin
                     cmd.out_sel = OUT_FEW;
                  end else begin
                     cmd.den_save = 1'b1;
                     cmd.mul_load = 1'b1;
                     cmd.mul_sel  = MS_N_SXY;
                  end
               end
               MS_N_SXY: begin
                  cmd.mul_load = 1'b1;
                  cmd.mul_sel  = MS_SX_SY;
               end
               MS_SX_SY: begin
                  cmd.num_save = 1'b1;
                  cmd.mul_load = 1'b1;
                  cmd.mul_sel  = MS_DEN_RES;
               end
               MS_DEN_RES: cmd.div_load = 1'b1;
               default: begin
               end
            endcase
         end
         ST_DIV_RUN: cmd.div_step = 1'b1;
         ST_FINISH:  cmd.out_sel = OUT_FIT;
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (cmd.out_sel != OUT_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= MS_N_SXX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_trig_enters_check: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && st.fit_trig) |=> (state_ff == ST_CHECK))
      else $error("window end request did not start the fit");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel != OUT_NONE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while an earlier one is still pending");

   a_mul_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_RUN) |-> (cnt_ff < STEP_W'(MUL_STEPS)))
      else $error("multiplier step count out of range");

   a_finish_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_DIV_RUN))
      else $error("fit finished without a completed division");

endmodule

FILE: src/window_least_squares_slope.sv
`timescale 1ns / 1ps
// Top level of the windowed least-squares slope block: joins the controller and the
// datapath to the request, result and register ports. Depends on wls_pkg and both interfaces.
//
//   Channel   Direction  Contents
//   req_ch    in         sample, last_sample (valid/ready)
//   rsp_ch    out        slope, status (valid/ready)
//   csr_*     in         window_start, window_end, range_resolution writes
//
// A request away from the window end is taken in the cycle that offers it, so samples stream at
// one per clock while no result is waiting. After the request at the window end, the request side
// is held off while the shared 24-step shift-add multiplier forms up to five products and the
// divider runs 47 steps.
// Reset is synchronous; the configuration takes its reset values and the trace restarts.
// A result that the receiver has not yet taken holds off every request until it is taken.
module window_least_squares_slope import wls_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   wls_req_if.sink              req_ch,
   wls_rsp_if.source            rsp_ch
);

   wls_cmd_type  cmd;
   wls_stat_type st;

   wls_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   wls_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_sample (req_ch.sample),
      .req_last   (req_ch.last_sample),
      .cmd        (cmd),
      .st         (st),
      .rsp_slope  (rsp_ch.slope),
      .rsp_status (rsp_ch.status)
   );

endmodule
